// ----- design/ial_pkg.sv -----
package ial_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int GRP_SIZE     = 8;

    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int OUT_W = 7;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } t_cell_ctl;

endpackage

// ----- design/indexed_array_list.sv -----
// Ordered list of up to CAPACITY signed 32-bit entries with a fill count.
// Requests arrive on the slave stream: tuser carries the operation (get,
// insert, remove, search), tdata carries the position and the value. Each
// request produces exactly one result transaction on the master stream:
// tdata carries the read value, the found index and the count after the
// operation, and tuser carries the status.
// Storage is a row of cells, one entry each; an insert or a remove moves
// every affected entry to its neighbour in the same cycle, and every cell
// compares its entry against the search value in parallel.
// A request is taken only while the block is idle. The cells register their
// compare and select flags, groups of eight cells are reduced into a
// registered stage, and the final reduction loads the output register; a
// new request is taken only after the result of the previous one has been
// loaded into the output register.
// When the receiver stalls, the result is held and the next request may
// still be accepted; it then waits in its final stage until the held result
// has been taken, and the list is updated only when its result is loaded.
// Reset empties the list and drops any pending result; no clearing pass is
// needed.
module indexed_array_list #(
    parameter int CAPACITY = ial_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // position[6:0], item_value[38:7], zero pad
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // read_value[31:0], found_index[38:32],
                                     // entry_count[45:39], zero pad
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    localparam int VW    = ial_pkg::VAL_W;
    localparam int OW    = ial_pkg::OUT_W;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > OW) ? CNT_W : OW;
    localparam int TAG_W = (IDX_W > OW) ? IDX_W : OW;
    localparam int GRP   = ial_pkg::GRP_SIZE;
    localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;
    localparam int NPAD  = NGRP * GRP;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CELL = 2'd1;
    localparam logic [1:0] S_GRP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [1:0]          r_op;
    logic [OW-1:0]       r_pos;
    logic [VW-1:0]       r_val;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic                r_m_valid;
    logic [VW-1:0]       r_rd;
    logic [OW-1:0]       r_fidx;
    logic [1:0]          r_status;
    logic [OW-1:0]       r_cnt_out;

    logic                w_accept;
    logic                w_fire;
    logic                w_ins_ok;
    logic                w_rem_ok;
    logic [VW-1:0]       n_rd;
    logic [OW-1:0]       n_fidx;
    logic [1:0]          n_status;
    logic [CMP_W-1:0]    w_pos_e;
    logic [CMP_W-1:0]    w_cnt_e;
    logic [CMP_W-1:0]    w_new_cnt_e;
    logic [TAG_W-1:0]    w_tag_e;

    ial_pkg::t_cell_ctl  w_ctl;
    logic [CMP_W-1:0]    w_count_c;

    logic [VW-1:0]       w_entry [CAPACITY];
    logic [NPAD-1:0]     w_hit;
    logic [NPAD-1:0]     w_sel;
    logic [NPAD*IDX_W-1:0] w_tag;
    logic [NPAD*VW-1:0]  w_data;

    logic [NGRP-1:0]       n_g_hit;
    logic [NGRP-1:0]       n_g_sel;
    logic [NGRP*IDX_W-1:0] n_g_tag;
    logic [NGRP*VW-1:0]    n_g_data;
    logic [NGRP-1:0]       r_g_hit;
    logic [NGRP-1:0]       r_g_sel;
    logic [NGRP*IDX_W-1:0] r_g_tag;
    logic [NGRP*VW-1:0]    r_g_data;

    logic                w_f_hit;
    logic [IDX_W-1:0]    w_f_tag;
    logic                w_f_sel;
    logic [VW-1:0]       w_f_data;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_fire     = (r_state == S_FIN) && (!r_m_valid || i_m_tready);

    assign w_ctl.ins = w_fire && (r_op == ial_pkg::OP_INSERT) && w_ins_ok;
    assign w_ctl.rem = w_fire && (r_op == ial_pkg::OP_REMOVE) && w_rem_ok;
    assign w_ctl.pos = r_pos;
    assign w_ctl.val = r_val;
    assign w_count_c = CMP_W'(r_count);

    for (genvar i = 0; i < NPAD; i++) begin : g_cells
        if (i < CAPACITY) begin : g_real
            logic [VW-1:0] w_prev;
            logic [VW-1:0] w_next;
            if (i == 0) begin : g_first
                assign w_prev = w_entry[i];
            end else begin : g_mid_lo
                assign w_prev = w_entry[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign w_next = w_entry[i];
            end else begin : g_mid_hi
                assign w_next = w_entry[i+1];
            end
            ial_cell #(
                .IDX   (i),
                .CMP_W (CMP_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_count (w_count_c),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_entry (w_entry[i]),
                .o_hit   (w_hit[i]),
                .o_sel   (w_sel[i])
            );
            assign w_tag[i*IDX_W +: IDX_W] = IDX_W'(i);
            assign w_data[i*VW +: VW]      = w_entry[i];
        end else begin : g_pad
            assign w_hit[i]                = 1'b0;
            assign w_sel[i]                = 1'b0;
            assign w_tag[i*IDX_W +: IDX_W] = '0;
            assign w_data[i*VW +: VW]      = '0;
        end
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_groups
        ial_reduce #(
            .N  (GRP),
            .TW (IDX_W),
            .W  (VW)
        ) u_grp (
            .i_hit  (w_hit[g*GRP +: GRP]),
            .i_tag  (w_tag[g*GRP*IDX_W +: GRP*IDX_W]),
            .i_sel  (w_sel[g*GRP +: GRP]),
            .i_data (w_data[g*GRP*VW +: GRP*VW]),
            .o_hit  (n_g_hit[g]),
            .o_tag  (n_g_tag[g*IDX_W +: IDX_W]),
            .o_sel  (n_g_sel[g]),
            .o_data (n_g_data[g*VW +: VW])
        );
    end

    always_ff @(posedge i_clk) begin
        r_g_hit  <= n_g_hit;
        r_g_sel  <= n_g_sel;
        r_g_tag  <= n_g_tag;
        r_g_data <= n_g_data;
    end

    ial_reduce #(
        .N  (NGRP),
        .TW (IDX_W),
        .W  (VW)
    ) u_final (
        .i_hit  (r_g_hit),
        .i_tag  (r_g_tag),
        .i_sel  (r_g_sel),
        .i_data (r_g_data),
        .o_hit  (w_f_hit),
        .o_tag  (w_f_tag),
        .o_sel  (w_f_sel),
        .o_data (w_f_data)
    );

    assign w_pos_e = CMP_W'(r_pos);
    assign w_cnt_e = CMP_W'(r_count);
    assign w_tag_e = TAG_W'(w_f_tag);

    always_comb begin
        n_rd     = '0;
        n_fidx   = '1;
        n_status = ial_pkg::ST_OK;
        n_count  = r_count;
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        case (r_op)
            ial_pkg::OP_GET: begin
                if ((w_pos_e < w_cnt_e) && (w_pos_e < CMP_W'(CAPACITY))) begin
                    n_rd = w_f_data;
                end else begin
                    n_rd     = '1;
                    n_status = ial_pkg::ST_BAD_INDEX;
                end
            end
            ial_pkg::OP_INSERT: begin
                if (w_pos_e > w_cnt_e) begin
                    n_status = ial_pkg::ST_BAD_INDEX;
                end else if (w_cnt_e >= CMP_W'(CAPACITY)) begin
                    n_status = ial_pkg::ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            ial_pkg::OP_REMOVE: begin
                if (w_pos_e >= w_cnt_e) begin
                    n_status = ial_pkg::ST_BAD_INDEX;
                end else begin
                    w_rem_ok = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            ial_pkg::OP_SEARCH: begin
                if (w_f_hit) begin
                    n_fidx = w_tag_e[OW-1:0];
                end else begin
                    n_status = ial_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ial_pkg::ST_OK;
            end
        endcase
    end

    assign w_new_cnt_e = CMP_W'(n_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CELL;
                end
            end
            S_CELL: begin
                n_state = S_GRP;
            end
            S_GRP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tuser;
            r_pos <= i_s_tdata[6:0];
            r_val <= i_s_tdata[38:7];
        end
        if (w_fire) begin
            r_rd      <= n_rd;
            r_fidx    <= n_fidx;
            r_status  <= n_status;
            r_cnt_out <= w_new_cnt_e[OW-1:0];
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_cnt_out, r_fidx, r_rd};
    assign o_m_tuser  = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
                            || r_count == $past(r_count) + 1'b1
                            || r_count == $past(r_count) - 1'b1))
        else $error("fill count moved by more than one");

    a_get_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_op == ial_pkg::OP_GET && n_status == ial_pkg::ST_OK)
        |-> w_f_sel)
        else $error("valid get found no selected cell");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_status == ial_pkg::ST_FULL) |-> (w_cnt_e == CMP_W'(CAPACITY)))
        else $error("full status with free space");

endmodule

// ----- design/ial_cell.sv -----
module ial_cell #(
    parameter int IDX   = 0,
    parameter int CMP_W = 7
) (
    input  logic                        i_clk,
    input  ial_pkg::t_cell_ctl          i_ctl,
    input  logic [CMP_W-1:0]            i_count,
    input  logic [ial_pkg::VAL_W-1:0]   i_prev,
    input  logic [ial_pkg::VAL_W-1:0]   i_next,
    output logic [ial_pkg::VAL_W-1:0]   o_entry,
    output logic                        o_hit,
    output logic                        o_sel
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [ial_pkg::VAL_W-1:0] r_entry;
    logic [ial_pkg::VAL_W-1:0] n_entry;
    logic                      r_hit;
    logic                      n_hit;
    logic                      r_sel;
    logic                      n_sel;
    logic [CMP_W-1:0]          w_pos;

    assign w_pos = CMP_W'(i_ctl.pos);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && (MY_IDX > w_pos)) begin
            n_entry = i_prev;
        end else if (i_ctl.ins && (MY_IDX == w_pos)) begin
            n_entry = i_ctl.val;
        end else if (i_ctl.rem && (MY_IDX >= w_pos)) begin
            n_entry = i_next;
        end
        n_hit = (r_entry == i_ctl.val) && (MY_IDX < i_count);
        n_sel = (MY_IDX == w_pos);
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
        r_sel   <= n_sel;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_sel   = r_sel;

endmodule

// ----- design/ial_reduce.sv -----
module ial_reduce #(
    parameter int N  = 8,
    parameter int TW = 6,
    parameter int W  = 32
) (
    input  logic [N-1:0]    i_hit,
    input  logic [N*TW-1:0] i_tag,
    input  logic [N-1:0]    i_sel,
    input  logic [N*W-1:0]  i_data,
    output logic            o_hit,
    output logic [TW-1:0]   o_tag,
    output logic            o_sel,
    output logic [W-1:0]    o_data
);

    always_comb begin
        o_hit  = |i_hit;
        o_sel  = |i_sel;
        o_tag  = '0;
        o_data = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_hit[i]) begin
                o_tag = i_tag[i*TW +: TW];
            end
        end
        for (int i = 0; i < N; i++) begin
            if (i_sel[i]) begin
                o_data = o_data | i_data[i*W +: W];
            end
        end
    end

endmodule

// ----- sim/tb_indexed_array_list.sv -----
module tb_indexed_array_list;

    localparam int CAP        = ial_pkg::CAPACITY_DEF;
    localparam int RESET_CYC  = 12;
    localparam int HOLD_CYC   = 300;
    localparam int DRAIN_CYC  = 20;
    localparam int LIMIT      = 200000;
    localparam int MODE_GROW  = 0;
    localparam int MODE_MIX   = 1;
    localparam int MODE_SHRINK = 2;

    typedef struct packed {
        logic [1:0]                op;
        logic [ial_pkg::POS_W-1:0] pos;
        logic [ial_pkg::VAL_W-1:0] val;
    } t_req;

    typedef struct packed {
        logic [ial_pkg::VAL_W-1:0] read_value;
        logic [ial_pkg::OUT_W-1:0] found_index;
        logic [1:0]                status;
        logic [ial_pkg::OUT_W-1:0] entry_count;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = ial_pkg::OP_GET;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    indexed_array_list #(.CAPACITY(CAP)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_req             pending_reqs[$];
    t_resp            expected_resps[$];
    t_req             offered_req;
    bit               req_taken = 1'b0;
    bit               rx_hold = 1'b0;
    int               n_accepted = 0;
    int               n_errors = 0;
    int               cycles = 0;

    logic [ial_pkg::VAL_W-1:0] list_mem[CAP];
    int               list_len = 0;

    int               gen_count = 0;
    logic [ial_pkg::VAL_W-1:0] value_pool[16];

    function automatic t_resp apply_request(t_req rq);
        t_resp r;
        int    i;
        r.read_value  = '0;
        r.found_index = '1;
        r.status      = ial_pkg::ST_OK;
        case (rq.op)
            ial_pkg::OP_GET: begin
                if (rq.pos < list_len) begin
                    r.read_value = list_mem[rq.pos];
                end else begin
                    r.read_value = '1;
                    r.status     = ial_pkg::ST_BAD_INDEX;
                end
            end
            ial_pkg::OP_INSERT: begin
                if (rq.pos > list_len) begin
                    r.status = ial_pkg::ST_BAD_INDEX;
                end else if (list_len >= CAP) begin
                    r.status = ial_pkg::ST_FULL;
                end else begin
                    for (i = list_len; i > rq.pos; i--) list_mem[i] = list_mem[i-1];
                    list_mem[rq.pos] = rq.val;
                    list_len++;
                end
            end
            ial_pkg::OP_REMOVE: begin
                if (rq.pos >= list_len) begin
                    r.status = ial_pkg::ST_BAD_INDEX;
                end else begin
                    for (i = rq.pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            default: begin
                r.status = ial_pkg::ST_NOT_FOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == rq.val) begin
                        r.found_index = ial_pkg::OUT_W'(i);
                        r.status      = ial_pkg::ST_OK;
                        break;
                    end
                end
            end
        endcase
        r.entry_count = ial_pkg::OUT_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        n_errors++;
    endtask

    task automatic push_req(logic [1:0] op, logic [ial_pkg::POS_W-1:0] pos,
                            logic [ial_pkg::VAL_W-1:0] val);
        t_req rq;
        rq.op  = op;
        rq.pos = pos;
        rq.val = val;
        pending_reqs.push_back(rq);
        if (op == ial_pkg::OP_INSERT && pos <= gen_count && gen_count < CAP) begin
            gen_count++;
            value_pool[$urandom_range(15)] = val;
        end else if (op == ial_pkg::OP_REMOVE && pos < gen_count) begin
            gen_count--;
        end
    endtask

    task automatic push_random(int mode);
        int                        r;
        bit                        bad;
        logic [1:0]                op;
        logic [ial_pkg::POS_W-1:0] pos;
        logic [ial_pkg::VAL_W-1:0] val;
        r   = $urandom_range(99);
        bad = ($urandom_range(9) == 0);
        if (mode == MODE_GROW) begin
            op = (r < 70) ? ial_pkg::OP_INSERT : (r < 80) ? ial_pkg::OP_GET :
                 (r < 90) ? ial_pkg::OP_REMOVE : ial_pkg::OP_SEARCH;
        end else if (mode == MODE_SHRINK) begin
            op = (r < 75) ? ial_pkg::OP_REMOVE : (r < 85) ? ial_pkg::OP_GET :
                 (r < 92) ? ial_pkg::OP_INSERT : ial_pkg::OP_SEARCH;
        end else begin
            op = (r < 25) ? ial_pkg::OP_INSERT : (r < 50) ? ial_pkg::OP_GET :
                 (r < 75) ? ial_pkg::OP_REMOVE : ial_pkg::OP_SEARCH;
        end
        case (op)
            ial_pkg::OP_INSERT: begin
                if (bad && gen_count < CAP)
                    pos = ial_pkg::POS_W'($urandom_range(CAP, gen_count + 1));
                else
                    pos = ial_pkg::POS_W'($urandom_range(gen_count, 0));
            end
            ial_pkg::OP_GET, ial_pkg::OP_REMOVE: begin
                if (bad || gen_count == 0)
                    pos = ial_pkg::POS_W'($urandom_range(CAP, gen_count));
                else
                    pos = ial_pkg::POS_W'($urandom_range(gen_count - 1, 0));
            end
            default: pos = ial_pkg::POS_W'($urandom_range(CAP, 0));
        endcase
        case ($urandom_range(3))
            0: val = $urandom;
            1: val = $urandom_range(8) - 4;
            2: val = value_pool[$urandom_range(15)];
            default: begin
                case ($urandom_range(3))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7FFF_FFFF;
                    2: val = 32'h0000_0000;
                    default: val = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        if (op == ial_pkg::OP_SEARCH && $urandom_range(1) == 1)
            val = value_pool[$urandom_range(15)];
        push_req(op, pos, val);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_s_tvalid || expected_resps.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender side: a new transaction is offered once the previous one has gone.
    always @(negedge i_clk) begin
        int tx_idle;
        tx_idle = (n_accepted < 240) ? 21 : (n_accepted < 480) ? 62 : 0;
        if (i_rst_n && (req_taken || !i_s_tvalid)) begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle) begin
                offered_req = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {1'b0, offered_req.val, offered_req.pos};
                i_s_tuser  <= offered_req.op;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        int rx_idle;
        rx_idle = (n_accepted < 240) ? 62 : (n_accepted < 480) ? 21 : 0;
        i_m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_resps.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[31:0], '0);
            end else begin
                want = expected_resps.pop_front();
                if (o_m_tdata[31:0] !== want.read_value)
                    report_mismatch("read_value", o_m_tdata[31:0], want.read_value);
                if (o_m_tdata[38:32] !== want.found_index)
                    report_mismatch("found_index", 32'(o_m_tdata[38:32]),
                                    32'(want.found_index));
                if (o_m_tuser !== want.status)
                    report_mismatch("status", 32'(o_m_tuser), 32'(want.status));
                if (o_m_tdata[45:39] !== want.entry_count)
                    report_mismatch("entry_count", 32'(o_m_tdata[45:39]),
                                    32'(want.entry_count));
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_resps.push_back(apply_request(offered_req));
            n_accepted++;
            req_taken = 1'b1;
        end
    end

    // The receiver stops for a long stretch so that the block backs up.
    initial begin
        wait (n_accepted >= 150);
        rx_hold = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end

    initial begin
        int k;
        for (k = 0; k < 16; k++) value_pool[k] = '0;
        for (k = 0; k < CAP; k++) list_mem[k] = '0;
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_req(ial_pkg::OP_GET,    7'd0,  32'h0000_0000);
        push_req(ial_pkg::OP_REMOVE, 7'd0,  32'h0000_0000);
        push_req(ial_pkg::OP_SEARCH, 7'd0,  32'h0000_0000);
        push_req(ial_pkg::OP_INSERT, 7'd1,  32'h1234_5678);
        push_req(ial_pkg::OP_INSERT, 7'd0,  32'h7FFF_FFFF);
        push_req(ial_pkg::OP_INSERT, 7'd0,  32'h8000_0000);
        push_req(ial_pkg::OP_INSERT, 7'd2,  32'hFFFF_FFFF);
        push_req(ial_pkg::OP_INSERT, 7'd1,  32'h0000_0000);
        push_req(ial_pkg::OP_INSERT, 7'd1,  32'h7FFF_FFFF);
        push_req(ial_pkg::OP_SEARCH, 7'd0,  32'h7FFF_FFFF);
        push_req(ial_pkg::OP_SEARCH, 7'd64, 32'h0001_2345);
        push_req(ial_pkg::OP_GET,    7'd0,  32'h0000_0000);
        push_req(ial_pkg::OP_GET,    7'd4,  32'h0000_0000);
        push_req(ial_pkg::OP_GET,    7'd5,  32'h0000_0000);
        push_req(ial_pkg::OP_GET,    7'd64, 32'h0000_0000);
        push_req(ial_pkg::OP_REMOVE, 7'd5,  32'h0000_0000);
        push_req(ial_pkg::OP_REMOVE, 7'd2,  32'h0000_0000);
        push_req(ial_pkg::OP_REMOVE, 7'd0,  32'h0000_0000);
        push_req(ial_pkg::OP_SEARCH, 7'd0,  32'hFFFF_FFFF);
        push_req(ial_pkg::OP_INSERT, 7'd64, 32'h5555_5555);
        push_req(ial_pkg::OP_INSERT, 7'd3,  32'hAAAA_AAAA);
        push_req(ial_pkg::OP_REMOVE, 7'd3,  32'h0000_0000);
        wait_idle();

        for (k = 0; k < 330; k++) begin
            case ((k / 60) % 4)
                0, 1: push_random(MODE_GROW);
                2: push_random(MODE_MIX);
                default: push_random(MODE_SHRINK);
            endcase
        end
        wait_idle();
        for (k = 0; k < 350; k++) begin
            case ((k / 60) % 4)
                0: push_random(MODE_SHRINK);
                1, 2: push_random(MODE_GROW);
                default: push_random(MODE_MIX);
            endcase
        end
        wait_idle();
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (expected_resps.size() != 0)
            report_mismatch("results missing", expected_resps.size(), 0);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ial_pkg.sv
design/ial_cell.sv
design/ial_reduce.sv
design/indexed_array_list.sv
sim/tb_indexed_array_list.sv
